@@ hw/rtl/srcd_pkg.sv @@
// ----------------------------------------------------------------------------
// srcd_pkg
// Shared types and constants of the stepper ramp clock divider.
// ----------------------------------------------------------------------------
package srcd_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 64;
  localparam int OutDataW = 136;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACCEL = 2'd0,
    REG_VEL   = 2'd1,
    REG_STEP  = 2'd2,
    REG_CLK   = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] AccelReset = 16'd1000;
  localparam logic [19:0] VelReset   = 20'd10000;
  localparam logic [15:0] StepReset  = 16'd10;
  localparam logic [31:0] ClkReset   = 32'd1000000;

  localparam logic [31:0] Ones32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [39:0] ramp_length;
    logic [31:0] cruise_divider;
    logic [31:0] ramp_divider;
    logic [31:0] step_frequency;
    logic        in_ramp;
  } result_t;

endpackage

@@ hw/rtl/srcd_div_cell.sv @@
// ----------------------------------------------------------------------------
// srcd_div_cell
// One restoring division step: shift in a dividend bit, compare, subtract.
// ----------------------------------------------------------------------------
module srcd_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0] t;
  logic [DW:0] diff;
  logic        ge;

  assign t    = {rem_i, num_i[NW-1]};
  assign diff = t - {1'b0, den_i};
  assign ge   = t >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[DW-1:0] : t[DW-1:0];
      num_o  <= {num_i[NW-2:0], 1'b0};
      quo_o  <= {quo_i[NW-2:0], ge};
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

@@ hw/rtl/srcd_div_chain.sv @@
// ----------------------------------------------------------------------------
// srcd_div_chain
// Row of division cells, one quotient bit per cell, with side data in step.
// ----------------------------------------------------------------------------
module srcd_div_chain #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [NW:0]         vld_a;
  logic [NW:0][DW-1:0] rem_a;
  logic [NW:0][NW-1:0] num_a;
  logic [NW:0][NW-1:0] quo_a;
  logic [NW:0][DW-1:0] den_a;
  logic [NW:0][SW-1:0] side_a;

  assign vld_a[0]  = in_vld;
  assign rem_a[0]  = '0;
  assign num_a[0]  = in_num;
  assign quo_a[0]  = '0;
  assign den_a[0]  = in_den;
  assign side_a[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    srcd_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (vld_a[k]),
      .rem_i  (rem_a[k]),
      .num_i  (num_a[k]),
      .quo_i  (quo_a[k]),
      .den_i  (den_a[k]),
      .side_i (side_a[k]),
      .vld_o  (vld_a[k+1]),
      .rem_o  (rem_a[k+1]),
      .num_o  (num_a[k+1]),
      .quo_o  (quo_a[k+1]),
      .den_o  (den_a[k+1]),
      .side_o (side_a[k+1])
    );
  end

  assign out_vld  = vld_a[NW];
  assign out_quo  = quo_a[NW];
  assign out_side = side_a[NW];

endmodule

@@ hw/rtl/srcd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// srcd_sqrt_cell
// One digit step of the integer square root: two radicand bits per cell.
// ----------------------------------------------------------------------------
module srcd_sqrt_cell #(
  parameter int XW = 8,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_i,
  input  logic [XW/2:0]    rem_i,
  input  logic [XW-1:0]    x_i,
  input  logic [XW/2-1:0]  root_i,
  input  logic [SW-1:0]    side_i,
  output logic             vld_o,
  output logic [XW/2:0]    rem_o,
  output logic [XW-1:0]    x_o,
  output logic [XW/2-1:0]  root_o,
  output logic [SW-1:0]    side_o
);

  localparam int RW = XW / 2;

  logic [RW+2:0] t;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  assign t     = {rem_i, x_i[XW-1:XW-2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = t - trial;
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[RW:0] : t[RW:0];
      x_o    <= {x_i[XW-3:0], 2'b00};
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

@@ hw/rtl/srcd_sqrt_chain.sv @@
// ----------------------------------------------------------------------------
// srcd_sqrt_chain
// Row of square root cells, one root bit per cell, with side data in step.
// ----------------------------------------------------------------------------
module srcd_sqrt_chain #(
  parameter int XW = 8,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [XW-1:0]   in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [XW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = XW / 2;

  logic [RW:0]         vld_a;
  logic [RW:0][RW:0]   rem_a;
  logic [RW:0][XW-1:0] x_a;
  logic [RW:0][RW-1:0] root_a;
  logic [RW:0][SW-1:0] side_a;

  assign vld_a[0]  = in_vld;
  assign rem_a[0]  = '0;
  assign x_a[0]    = in_x;
  assign root_a[0] = '0;
  assign side_a[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    srcd_sqrt_cell #(.XW(XW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_i  (vld_a[k]),
      .rem_i  (rem_a[k]),
      .x_i    (x_a[k]),
      .root_i (root_a[k]),
      .side_i (side_a[k]),
      .vld_o  (vld_a[k+1]),
      .rem_o  (rem_a[k+1]),
      .x_o    (x_a[k+1]),
      .root_o (root_a[k+1]),
      .side_o (side_a[k+1])
    );
  end

  assign out_vld  = vld_a[RW];
  assign out_root = root_a[RW];
  assign out_side = side_a[RW];

endmodule

@@ hw/rtl/stepper_ramp_clock_divider.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_clock_divider
// Trapezoidal ramp step rate and timer dividers, one position per word.
// ----------------------------------------------------------------------------
// Pipeline: two front stages, 40+61+30+32+48 division cells, 31 square root
// cells, two compute stages, one output register.
// Throughput: one word per cycle unless the output stalls; each cell row takes one bit per cell.
// Output: a two-word buffer; the input stalls only when both words wait.
// Reset: synchronous, clears all valid flags and loads the register defaults.
module stepper_ramp_clock_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srcd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [srcd_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // steps_done[31:0], steps_left[63:32]
  input  logic [srcd_pkg::InDataW-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // step_frequency[31:0], ramp_divider[63:32], cruise_divider[95:64],
  // ramp_length[135:96]
  output logic [srcd_pkg::OutDataW-1:0]   m_tdata,
  // in_ramp[0]
  output logic                            m_tuser
);

  import srcd_pkg::*;

  logic [15:0] accel;
  logic [19:0] vel;
  logic [15:0] step;
  logic [31:0] tclk;

  logic [19:0] vel1;
  logic [31:0] as_prod;
  logic [39:0] vsq;
  logic [32:0] den1;
  logic [29:0] a15;
  logic [29:0] cden;
  logic [47:0] sclk;

  logic        en;
  logic        f1_vld;
  logic [31:0] f1_n;
  logic        f2_vld;
  logic [31:0] f2_n;

  logic        c1_vld;
  logic [39:0] c1_quo;
  logic [31:0] c1_n;

  logic        p_vld;
  logic        p_inr;
  logic [39:0] p_rl;
  logic [53:0] p_mul;
  logic [32:0] n1;
  logic [62:0] mul_full;

  logic        c2_vld;
  logic [60:0] c2_quo;
  logic [40:0] c2_side;

  logic        c3_vld;
  logic [30:0] c3_root;
  logic [40:0] c3_side;

  logic        c4_vld;
  logic [29:0] c4_quo;
  logic [71:0] c4_side;

  logic        s_vld;
  logic [31:0] s_freq;
  logic        s_inr;
  logic [39:0] s_rl;
  logic [31:0] freq_next;

  logic        c5_vld;
  logic [31:0] c5_quo;
  logic [72:0] c5_side;

  logic        c6_vld;
  logic [47:0] c6_quo;
  logic [104:0] c6_side;

  result_t     res_new;
  result_t     o0;
  result_t     o1;
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic        push;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= AccelReset;
      vel   <= VelReset;
      step  <= StepReset;
      tclk  <= ClkReset;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACCEL: accel <= cfg_data[15:0];
        REG_VEL:   vel   <= cfg_data[19:0];
        REG_STEP:  step  <= cfg_data[15:0];
        REG_CLK:   tclk  <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign vel1    = (vel == '0) ? 20'd1 : vel;
  assign as_prod = accel * step;

  always_ff @(posedge clk) begin
    vsq  <= vel * vel;
    den1 <= {as_prod, 1'b0};
    a15  <= accel * 14'd15625;
    cden <= vel1 * 10'd1000;
    sclk <= step * tclk;
  end

  assign en       = !(c6_vld && cnt == 2'd2 && !m_tready);
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      p_vld  <= 1'b0;
      s_vld  <= 1'b0;
    end else if (en) begin
      f1_vld <= s_tvalid;
      f2_vld <= f1_vld;
      p_vld  <= c1_vld;
      s_vld  <= c4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_n <= (s_tdata[31:0] <= s_tdata[63:32]) ? s_tdata[31:0] : s_tdata[63:32];
      f2_n <= f1_n;
    end
  end

  srcd_div_chain #(.NW(40), .DW(33), .SW(32)) u_rlen (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (f2_vld), .in_num (vsq), .in_den (den1), .in_side (f2_n),
    .out_vld (c1_vld), .out_quo (c1_quo), .out_side (c1_n)
  );

  assign n1       = {1'b0, c1_n} + 33'd1;
  assign mul_full = a15 * n1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_inr <= {8'd0, c1_n} <= c1_quo;
      p_rl  <= c1_quo;
      p_mul <= mul_full[53:0];
    end
  end

  srcd_div_chain #(.NW(61), .DW(16), .SW(41)) u_rquo (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (p_vld), .in_num ({p_mul, 7'd0}), .in_den (step),
    .in_side ({p_inr, p_rl}),
    .out_vld (c2_vld), .out_quo (c2_quo), .out_side (c2_side)
  );

  srcd_sqrt_chain #(.XW(62), .SW(41)) u_sqrt (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (c2_vld), .in_x ({1'b0, c2_quo}), .in_side (c2_side),
    .out_vld (c3_vld), .out_root (c3_root), .out_side (c3_side)
  );

  srcd_div_chain #(.NW(30), .DW(16), .SW(72)) u_cfreq (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (c3_vld), .in_num (cden), .in_den (step),
    .in_side ({c3_root, c3_side}),
    .out_vld (c4_vld), .out_quo (c4_quo), .out_side (c4_side)
  );

  always_comb begin
    priority if (step == '0) begin
      freq_next = Ones32;
    end else if (c4_side[40]) begin
      freq_next = {1'b0, c4_side[71:41]};
    end else begin
      freq_next = {2'b00, c4_quo};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_freq <= freq_next;
      s_inr  <= c4_side[40];
      s_rl   <= c4_side[39:0];
    end
  end

  srcd_div_chain #(.NW(32), .DW(32), .SW(73)) u_rdiv (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (s_vld), .in_num (tclk), .in_den (s_freq),
    .in_side ({s_freq, s_inr, s_rl}),
    .out_vld (c5_vld), .out_quo (c5_quo), .out_side (c5_side)
  );

  srcd_div_chain #(.NW(48), .DW(30), .SW(105)) u_cdiv (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (c5_vld), .in_num (sclk), .in_den (cden),
    .in_side ({c5_quo, c5_side}),
    .out_vld (c6_vld), .out_quo (c6_quo), .out_side (c6_side)
  );

  always_comb begin
    res_new.step_frequency = c6_side[72:41];
    res_new.ramp_divider   = c6_side[104:73];
    res_new.cruise_divider = (c6_quo[47:32] != '0) ? Ones32 : c6_quo[31:0];
    res_new.ramp_length    = c6_side[39:0];
    res_new.in_ramp        = c6_side[40];
  end

  assign push     = en && c6_vld;
  assign pop      = (cnt != 2'd0) && m_tready;
  assign cnt_next = cnt - {1'b0, pop} + {1'b0, push};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt - {1'b0, pop}) == 2'd0) begin
      o0 <= res_new;
    end else if (pop) begin
      o0 <= o1;
    end
    if (push && (cnt - {1'b0, pop}) != 2'd0) begin
      o1 <= res_new;
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = {o0.ramp_length, o0.cruise_divider, o0.ramp_divider, o0.step_frequency};
  assign m_tuser  = o0.in_ramp;

endmodule

@@ hw/rtl/srcd_check.sv @@
// ----------------------------------------------------------------------------
// srcd_check
// Port-level checks of the stepper ramp clock divider, bound to the top.
// ----------------------------------------------------------------------------
module srcd_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [srcd_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [srcd_pkg::CfgDataW-1:0] cfg_data,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [srcd_pkg::InDataW-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [srcd_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tuser
);

  import srcd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == '0 |-> m_tdata[63:32] == Ones32)
    else $error("zero frequency without saturated divider");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output free");

endmodule

bind stepper_ramp_clock_divider srcd_check u_srcd_check (.*);
